// ===== rtl/core/brtx_pkg.sv =====
`default_nettype none

package brtx_pkg;

  // ring dimensions
  localparam int unsigned MaxBlocks     = 16;
  localparam int unsigned MaxBlockBytes = 4096;

  localparam int unsigned IdxW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);
  localparam int unsigned LenW = $clog2(MaxBlockBytes + 1);
  localparam int unsigned OffW = $clog2(MaxBlockBytes);
  localparam int unsigned TotW = $clog2(MaxBlocks * MaxBlockBytes + 1);
  localparam int unsigned CfgW = LenW;

  // register indexes
  localparam logic CfgNumBlocks  = 1'b0;
  localparam logic CfgBlockBytes = 1'b1;

  typedef enum logic {
    OpWrite = 1'b0,
    OpFlush = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StFull    = 3'd1,
    StTooLong = 3'd2,
    StSinkErr = 3'd3,
    StEmpty   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle   = 4'b0001,
    SRead   = 4'b0010,
    SFetch  = 4'b0100,
    SFinish = 4'b1000
  } state_e;

  typedef struct packed {
    op_e             op;
    logic [LenW-1:0] length;
    logic [LenW-1:0] accepted;
    logic            sink_error;
  } item_t;

  typedef struct packed {
    status_e         status;
    logic [LenW-1:0] bytes_done;
    logic [TotW-1:0] bytes_left;
    logic            pending;
    logic [IdxW-1:0] copy_block;
    logic [OffW-1:0] copy_offset;
    logic            copy_valid;
    logic [IdxW-1:0] offer_block;
    logic [OffW-1:0] offer_offset;
    logic [LenW-1:0] offer_length;
  } res_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [TotW-1:0] total;
  } ring_t;

endpackage

`default_nettype wire

// ===== rtl/core/block_ring_tx_buffer_manager.sv =====
// an accepted word passes the SRead and SFinish states and then the output register on its way to a result word,
//   with an SFetch state between SRead and SFinish when a flush drains the head block and the next block holds data
//   (one more descriptor ram read for the new head)
// one item at a time: a new item is taken only in SIdle, after the result of the last one has left SFinish;
//   each item does a read-modify-write of the descriptor ram through its registered read port
// reset: asynchronous, clears busy flags, indices and byte count; the ring
//   uses 16 blocks of 4096 bytes; descriptor ram is not cleared, busy flags mask it
`default_nettype none

module block_ring_tx_buffer_manager
  import brtx_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration writes
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_index_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  // input items
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [31:0]     s_axis_tdata,   // length, accepted, sink_error
  input  wire logic            s_axis_tuser,   // operation
  // result items
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [79:0]          m_axis_tdata    // status, bytes_done, bytes_left, pending,
                                               // copy_block, copy_offset, copy_valid,
                                               // offer_block, offer_offset, offer_length
);

  logic [CntW-1:0] eff_blocks_q, eff_blocks_d;
  logic [LenW-1:0] eff_bytes_q, eff_bytes_d;
  logic [CntW-1:0] wr_blocks;
  logic [LenW-1:0] wr_bytes;

  item_t           item;
  res_t            res;
  ring_t           ring;
  logic            res_valid;
  logic            res_ready;

  logic            m_valid_q, m_valid_d;
  logic [79:0]     m_data_q, m_data_d;

  // configuration, clamped to the supported range on write
  assign wr_blocks = cfg_data_i[CntW-1:0];
  assign wr_bytes  = cfg_data_i[LenW-1:0];

  always_comb begin
    eff_blocks_d = eff_blocks_q;
    eff_bytes_d  = eff_bytes_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgNumBlocks: begin
          if (wr_blocks == '0) begin
            eff_blocks_d = CntW'(1);
          end else if (wr_blocks > CntW'(MaxBlocks)) begin
            eff_blocks_d = CntW'(MaxBlocks);
          end else begin
            eff_blocks_d = wr_blocks;
          end
        end
        CfgBlockBytes: begin
          if (wr_bytes == '0 || wr_bytes > LenW'(MaxBlockBytes)) begin
            eff_bytes_d = LenW'(MaxBlockBytes);
          end else begin
            eff_bytes_d = wr_bytes;
          end
        end
        default: begin
          eff_blocks_d = eff_blocks_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_blocks_q <= CntW'(MaxBlocks);
      eff_bytes_q  <= LenW'(MaxBlockBytes);
    end else begin
      eff_blocks_q <= eff_blocks_d;
      eff_bytes_q  <= eff_bytes_d;
    end
  end

  // input word unpacking
  assign item.op         = op_e'(s_axis_tuser);
  assign item.length     = s_axis_tdata[LenW-1:0];
  assign item.accepted   = s_axis_tdata[2*LenW-1:LenW];
  assign item.sink_error = s_axis_tdata[2*LenW];

  brtx_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_clear_i  (cfg_we_i),
    .eff_blocks_i (eff_blocks_q),
    .eff_bytes_i  (eff_bytes_q),
    .item_valid_i (s_axis_tvalid),
    .item_i       (item),
    .item_ready_o (s_axis_tready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .ring_o       (ring)
  );

  // output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_ready) begin
      m_valid_d = res_valid;
      if (res_valid) begin
        m_data_d = {res.offer_length, res.offer_offset, res.offer_block,
                    res.copy_valid, res.copy_offset, res.copy_block,
                    res.pending, res.bytes_left, res.bytes_done, res.status};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while the previous one is in progress");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring.full |-> !ring.empty)
    else $error("ring flagged full and empty together");

  a_cfg_clears_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (ring.empty && ring.total == '0))
    else $error("register write did not empty the ring");

endmodule

`default_nettype wire

// ===== rtl/core/brtx_ram.sv =====
`default_nettype none

module brtx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/brtx_engine.sv =====
`default_nettype none

module brtx_engine
  import brtx_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_clear_i,
  input  wire logic [CntW-1:0] eff_blocks_i,
  input  wire logic [LenW-1:0] eff_bytes_i,
  input  wire logic            item_valid_i,
  input  wire item_t           item_i,
  output logic                 item_ready_o,
  output logic                 res_valid_o,
  output res_t                 res_o,
  input  wire logic            res_ready_i,
  output ring_t                ring_o
);

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx,
                                              input logic [CntW-1:0] eff);
    logic [CntW-1:0] n;
    n = CntW'(idx) + CntW'(1);
    return (n >= eff) ? '0 : n[IdxW-1:0];
  endfunction

  state_e               state_q, state_d;
  item_t                item_q, item_d;
  logic [MaxBlocks-1:0] busy_q, busy_d;
  logic [IdxW-1:0]      prod_q, prod_d;
  logic [IdxW-1:0]      cons_q, cons_d;
  logic                 empty_q, empty_d;
  logic                 full_q, full_d;
  logic [TotW-1:0]      total_q, total_d;
  logic [OffW-1:0]      head_start_q, head_start_d;
  logic [LenW-1:0]      head_end_q, head_end_d;

  status_e              r_status_q, r_status_d;
  logic [LenW-1:0]      r_done_q, r_done_d;
  logic [IdxW-1:0]      r_cblk_q, r_cblk_d;
  logic [OffW-1:0]      r_coff_q, r_coff_d;
  logic                 r_cval_q, r_cval_d;
  logic                 r_derr_q, r_derr_d;

  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic [LenW-1:0]      ram_wdata;
  logic [IdxW-1:0]      ram_raddr;
  logic [LenW-1:0]      ram_rdata;

  logic [IdxW-1:0]      last_idx, prod_nxt, cons_nxt, cons_after;
  logic [CntW-1:0]      eff_m1;
  logic [LenW-1:0]      last_end, room, acc_w, acc_f, head_left, new_end;
  logic                 do_open;
  logic [LenW-1:0]      open_size;

  // descriptor end offsets, masked by the busy flags
  brtx_ram #(
    .Width (LenW),
    .Depth (MaxBlocks)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ring index arithmetic
  assign eff_m1     = eff_blocks_i - CntW'(1);
  assign last_idx   = (prod_q == '0) ? eff_m1[IdxW-1:0] : prod_q - IdxW'(1);
  assign prod_nxt   = next_idx(prod_q, eff_blocks_i);
  assign cons_nxt   = next_idx(cons_q, eff_blocks_i);
  assign cons_after = empty_q ? prod_q : cons_q;

  // read the last block while idle, the next head while retiring one
  assign ram_raddr = (state_q == SRead) ? cons_nxt : last_idx;

  // per-item arithmetic
  assign last_end  = busy_q[last_idx] ? ram_rdata : '0;
  assign room      = (last_end < eff_bytes_i) ? eff_bytes_i - last_end : '0;
  assign new_end   = last_end + item_q.length;
  assign acc_w     = (item_q.accepted > item_q.length) ? item_q.length : item_q.accepted;
  assign head_left = (head_end_q > LenW'(head_start_q)) ? head_end_q - LenW'(head_start_q)
                                                         : '0;
  assign acc_f     = (item_q.accepted > head_left) ? head_left : item_q.accepted;

  // item sequencing and descriptor update
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    busy_d       = busy_q;
    prod_d       = prod_q;
    cons_d       = cons_q;
    empty_d      = empty_q;
    full_d       = full_q;
    total_d      = total_q;
    head_start_d = head_start_q;
    head_end_d   = head_end_q;
    r_status_d   = r_status_q;
    r_done_d     = r_done_q;
    r_cblk_d     = r_cblk_q;
    r_coff_d     = r_coff_q;
    r_cval_d     = r_cval_q;
    r_derr_d     = r_derr_q;
    ram_we       = 1'b0;
    ram_waddr    = last_idx;
    ram_wdata    = '0;
    do_open      = 1'b0;
    open_size    = '0;

    case (state_q)
      SIdle: begin
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = SRead;
        end
      end
      SRead: begin
        state_d    = SFinish;
        r_status_d = StOk;
        r_done_d   = '0;
        r_cblk_d   = '0;
        r_coff_d   = '0;
        r_cval_d   = 1'b0;
        r_derr_d   = 1'b0;
        if (item_q.op == OpWrite) begin
          if (item_q.length > eff_bytes_i) begin
            r_status_d = StTooLong;
          end else if (item_q.length == '0) begin
            r_status_d = StOk;
          end else if (empty_q) begin
            // direct hand-off, keep only the unaccepted tail
            if (item_q.sink_error) begin
              r_status_d = StSinkErr;
              r_derr_d   = 1'b1;
            end else begin
              r_done_d = item_q.length;
              if (acc_w < item_q.length) begin
                do_open   = 1'b1;
                open_size = item_q.length - acc_w;
              end
            end
          end else if (busy_q[last_idx] && room >= item_q.length) begin
            // append to the last busy block
            ram_we    = 1'b1;
            ram_waddr = last_idx;
            ram_wdata = new_end;
            total_d   = total_q + TotW'(item_q.length);
            r_done_d  = item_q.length;
            r_cblk_d  = last_idx;
            r_coff_d  = last_end[OffW-1:0];
            r_cval_d  = 1'b1;
            if (last_idx == cons_q) begin
              head_end_d = new_end;
            end
          end else if (full_q) begin
            r_status_d = StFull;
          end else begin
            do_open   = 1'b1;
            open_size = item_q.length;
            r_done_d  = item_q.length;
          end

          // open a fresh block at the producer index
          if (do_open) begin
            busy_d[prod_q] = 1'b1;
            ram_we         = 1'b1;
            ram_waddr      = prod_q;
            ram_wdata      = open_size;
            total_d        = total_q + TotW'(open_size);
            r_cblk_d       = prod_q;
            r_coff_d       = '0;
            r_cval_d       = 1'b1;
            if (empty_q) begin
              cons_d       = prod_q;
              empty_d      = 1'b0;
              head_start_d = '0;
              head_end_d   = open_size;
            end
            prod_d = prod_nxt;
            if (prod_nxt == cons_after) begin
              full_d = 1'b1;
            end
          end
        end else begin
          if (empty_q) begin
            r_status_d = StEmpty;
          end else if (item_q.sink_error) begin
            r_status_d = StSinkErr;
          end else begin
            r_done_d = acc_f;
            total_d  = (total_q >= TotW'(acc_f)) ? total_q - TotW'(acc_f) : '0;
            if (acc_f == head_left) begin
              // head block drained, move on
              busy_d[cons_q] = 1'b0;
              full_d         = 1'b0;
              cons_d         = cons_nxt;
              head_start_d   = '0;
              if (!busy_d[cons_nxt]) begin
                empty_d = 1'b1;
              end else begin
                state_d = SFetch;
              end
            end else begin
              head_start_d = head_start_q + acc_f[OffW-1:0];
            end
          end
        end
      end
      SFetch: begin
        // end offset of the new head block
        head_end_d = ram_rdata;
        state_d    = SFinish;
      end
      SFinish: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    // register write empties the ring
    if (cfg_clear_i) begin
      busy_d  = '0;
      prod_d  = '0;
      cons_d  = '0;
      empty_d = 1'b1;
      full_d  = 1'b0;
      total_d = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      busy_q  <= '0;
      prod_q  <= '0;
      cons_q  <= '0;
      empty_q <= 1'b1;
      full_q  <= 1'b0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      prod_q  <= prod_d;
      cons_q  <= cons_d;
      empty_q <= empty_d;
      full_q  <= full_d;
      total_q <= total_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    head_start_q <= head_start_d;
    head_end_q   <= head_end_d;
    r_status_q   <= r_status_d;
    r_done_q     <= r_done_d;
    r_cblk_q     <= r_cblk_d;
    r_coff_q     <= r_coff_d;
    r_cval_q     <= r_cval_d;
    r_derr_q     <= r_derr_d;
  end

  // result word from the updated ring
  always_comb begin
    res_o.status       = r_status_q;
    res_o.bytes_done   = r_done_q;
    res_o.bytes_left   = total_q;
    res_o.pending      = r_derr_q || !empty_q;
    res_o.copy_block   = r_cblk_q;
    res_o.copy_offset  = r_coff_q;
    res_o.copy_valid   = r_cval_q;
    res_o.offer_block  = empty_q ? '0 : cons_q;
    res_o.offer_offset = empty_q ? '0 : head_start_q;
    res_o.offer_length = empty_q ? '0 : head_left;
  end

  assign item_ready_o = (state_q == SIdle);
  assign res_valid_o  = (state_q == SFinish);

  assign ring_o.empty = empty_q;
  assign ring_o.full  = full_q;
  assign ring_o.total = total_q;

endmodule

`default_nettype wire
